>>> src/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// Field widths, operation and status codes, and the controller/datapath
// command and status bundles of the sorted MAC set table.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int OPC_W  = 3;
  localparam int MAC_W  = 48;
  localparam int STAT_W = 3;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;
  localparam int CAP_W  = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_REWIND = 3'd3,
    OP_NEXT   = 3'd4
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_ENTRY    = 3'd5,
    ST_EMPTY    = 3'd6,
    ST_DONE     = 3'd7
  } status_t;

  typedef struct packed {
    logic    load;
    logic    srch_init;
    logic    srch_rd;
    logic    srch_upd;
    logic    eq_rd;
    logic    shift_init;
    logic    shift;
    logic    ins_write;
    logic    next_rd;
    logic    clear;
    logic    rewind;
    logic    res_wr;
    status_t res_status;
    logic    res_pos_lo;
    logic    res_mac_rd;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic             full;
    logic             srch_go;
    logic             lo_lt_count;
    logic             key_eq;
    logic             shift_done;
    logic             empty;
    logic             out_free;
  } dp_sts_t;

endpackage

>>> src/smt_in_if.sv
// ----------------------------------------------------------------------------
// smt_in_if
// Operation channel: opcode and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface smt_in_if import smt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [MAC_W-1:0] mac_key;

  modport source (output valid, output opcode, output mac_key, input ready);
  modport sink   (input valid, input opcode, input mac_key, output ready);
endinterface

>>> src/smt_out_if.sv
// ----------------------------------------------------------------------------
// smt_out_if
// Result channel: status, position, entry and fill level, valid/ready.
// ----------------------------------------------------------------------------
interface smt_out_if import smt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;
  logic [MAC_W-1:0]  mac_out;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, output status, output position, output mac_out,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input position, input mac_out,
                  input entry_count, output ready);
endinterface

>>> src/smt_cfg_if.sv
// ----------------------------------------------------------------------------
// smt_cfg_if
// Capacity register write channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface smt_cfg_if import smt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/sorted_mac_set_table.sv
// ----------------------------------------------------------------------------
// sorted_mac_set_table
// Holds up to DEPTH distinct 48-bit MAC addresses in ascending order in a
// single-port-read memory and serves one operation at a time: insert in
// order, binary-search lookup, clear, rewind and next-entry read-out. Each
// operation returns one result. A lookup is a binary search over the entries
// held; an insert runs the same search, then moves each entry above the
// insertion point up by one, from the top down, and writes the key in the
// gap. A new operation is taken the cycle after the previous result is
// placed in the output register, even while that result still waits to be
// taken. Capacity may be written while idle.
// ----------------------------------------------------------------------------
module sorted_mac_set_table import smt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  smt_in_if.sink    in_ch,
  smt_out_if.source out_ch,
  smt_cfg_if.sink   cfg_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  smt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  smt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_mac_key      (in_ch.mac_key),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_position    (out_ch.position),
    .out_mac_out     (out_ch.mac_out),
    .out_entry_count (out_ch.entry_count)
  );

endmodule

>>> src/smt_ctrl.sv
// ----------------------------------------------------------------------------
// smt_ctrl
// Sequencer: dispatches each operation, steps the binary search, runs the
// insert shift and hands the result to the output register.
// ----------------------------------------------------------------------------
module smt_ctrl import smt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH,
    S_SRCH_CMP,
    S_EQ_CMP,
    S_SHIFT,
    S_NEXT_WAIT,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   is_ins;

  assign in_ready = (state_r == S_IDLE);
  assign is_ins   = (sts.op == OP_INSERT);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_INSERT: begin
            if (sts.full) begin
              cmd.res_wr     = 1'b1;
              cmd.res_status = ST_FULL;
              state_nxt      = S_FIN;
            end else begin
              cmd.srch_init = 1'b1;
              state_nxt     = S_SRCH;
            end
          end
          OP_LOOKUP: begin
            cmd.srch_init = 1'b1;
            state_nxt     = S_SRCH;
          end
          OP_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.res_wr     = 1'b1;
            cmd.res_status = ST_DONE;
            state_nxt      = S_FIN;
          end
          OP_REWIND: begin
            cmd.rewind     = 1'b1;
            cmd.res_wr     = 1'b1;
            cmd.res_status = ST_DONE;
            state_nxt      = S_FIN;
          end
          OP_NEXT: begin
            if (sts.empty) begin
              cmd.res_wr     = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              cmd.next_rd = 1'b1;
              state_nxt   = S_NEXT_WAIT;
            end
          end
          default: begin
            cmd.res_wr     = 1'b1;
            cmd.res_status = ST_DONE;
            state_nxt      = S_FIN;
          end
        endcase
      end
      S_SRCH: begin
        priority if (sts.srch_go) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SRCH_CMP;
        end else if (sts.lo_lt_count) begin
          cmd.eq_rd = 1'b1;
          state_nxt = S_EQ_CMP;
        end else if (is_ins) begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.res_wr     = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRCH;
      end
      S_EQ_CMP: begin
        priority if (sts.key_eq) begin
          cmd.res_wr     = 1'b1;
          cmd.res_status = is_ins ? ST_DUP : ST_FOUND;
          cmd.res_pos_lo = 1'b1;
          state_nxt      = S_FIN;
        end else if (is_ins) begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.res_wr     = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        // write port is free once the last moved entry has landed
        if (sts.shift_done) begin
          cmd.ins_write  = 1'b1;
          cmd.res_wr     = 1'b1;
          cmd.res_status = ST_INSERTED;
          cmd.res_pos_lo = 1'b1;
          state_nxt      = S_FIN;
        end
      end
      S_NEXT_WAIT: begin
        cmd.res_wr     = 1'b1;
        cmd.res_status = ST_ENTRY;
        cmd.res_pos_lo = 1'b1;
        cmd.res_mac_rd = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/smt_dp.sv
// ----------------------------------------------------------------------------
// smt_dp
// Datapath: entry memory with one write and one registered read port, fill
// count, read cursor, search bounds, shift pointer, capacity register and
// the output register.
// ----------------------------------------------------------------------------
module smt_dp import smt_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [MAC_W-1:0]  in_mac_key,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [POS_W-1:0]  out_position,
  output logic [MAC_W-1:0]  out_mac_out,
  output logic [CNT_W-1:0]  out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic [MAC_W-1:0]  mem [DEPTH];
  logic [MAC_W-1:0]  rd_data_r;

  logic [OPC_W-1:0]  op_r;
  logic [MAC_W-1:0]  key_r;
  logic [CAP_W-1:0]  cap_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     cursor_r;
  logic [CW-1:0]     lo_r;
  logic [CW-1:0]     hi_r;
  logic [CW-1:0]     mid_r;
  logic [CW-1:0]     j_r;
  logic [AW-1:0]     wdst_r;
  logic              wr_pend_r;
  status_t           res_status_r;
  logic [POS_W-1:0]  res_pos_r;
  logic [MAC_W-1:0]  res_mac_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [MAC_W-1:0]  out_mac_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [CW:0]       mid_sum;
  logic [CW-1:0]     mid_w;
  logic [CW-1:0]     cur_eff;
  logic [CW-1:0]     j_dec;
  logic              full_w;
  logic              shift_more;
  logic              key_lt;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              shift_wr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [MAC_W-1:0]  wr_data;

  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w      = mid_sum[CW:1];
  assign cur_eff    = (cursor_r >= count_r) ? '0 : cursor_r;
  assign j_dec      = j_r - CW'(1);
  assign shift_more = (j_r > lo_r);
  assign key_lt     = (rd_data_r < key_r);
  assign full_w     = (XW'(count_r) >= XW'(cap_r)) || (count_r >= CW'(DEPTH));

  // read port: one user per cycle by construction of the sequencer
  assign rd_en = cmd.srch_rd | cmd.eq_rd | cmd.next_rd | (cmd.shift & shift_more);

  always_comb begin
    priority if (cmd.srch_rd) begin
      rd_addr = mid_w[AW-1:0];
    end else if (cmd.eq_rd) begin
      rd_addr = lo_r[AW-1:0];
    end else if (cmd.next_rd) begin
      rd_addr = cur_eff[AW-1:0];
    end else begin
      rd_addr = j_dec[AW-1:0];
    end
  end

  assign shift_wr = cmd.shift & wr_pend_r;
  assign wr_en    = shift_wr | cmd.ins_write;
  assign wr_addr  = shift_wr ? wdst_r : lo_r[AW-1:0];
  assign wr_data  = shift_wr ? rd_data_r : key_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      cursor_r    <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.ins_write) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.clear || cmd.rewind) begin
        cursor_r <= '0;
      end else if (cmd.next_rd) begin
        cursor_r <= cur_eff + CW'(1);
      end
      if (cmd.shift_init) begin
        wr_pend_r <= 1'b0;
      end else if (cmd.shift) begin
        wr_pend_r <= shift_more;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      key_r <= in_mac_key;
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= count_r;
    end else if (cmd.srch_upd) begin
      if (key_lt) begin
        lo_r <= mid_r + CW'(1);
      end else begin
        hi_r <= mid_r;
      end
    end else if (cmd.next_rd) begin
      lo_r <= cur_eff;
    end
    if (cmd.srch_rd) begin
      mid_r <= mid_w;
    end
    // move entries up from the top, one read and one write per cycle
    if (cmd.shift_init) begin
      j_r <= count_r;
    end else if (cmd.shift && shift_more) begin
      j_r    <= j_dec;
      wdst_r <= j_r[AW-1:0];
    end
    if (cmd.res_wr) begin
      res_status_r <= cmd.res_status;
      res_pos_r    <= cmd.res_pos_lo ? POS_W'(lo_r) : '0;
      res_mac_r    <= cmd.res_mac_rd ? rd_data_r : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_mac_r    <= res_mac_r;
      out_cnt_r    <= CNT_W'(count_r);
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_pos_r;
  assign out_mac_out     = out_mac_r;
  assign out_entry_count = out_cnt_r;

  assign sts.op          = op_r;
  assign sts.full        = full_w;
  assign sts.srch_go     = (lo_r < hi_r);
  assign sts.lo_lt_count = (lo_r < count_r);
  assign sts.key_eq      = (rd_data_r == key_r);
  assign sts.shift_done  = !shift_more && !wr_pend_r;
  assign sts.empty       = (count_r == '0);
  assign sts.out_free    = !out_valid_r || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count beyond table depth");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("read cursor beyond fill count");

  a_ins_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_write |-> (!full_w && !wr_pend_r && lo_r <= count_r))
    else $error("key written into full table or over a pending move");

  a_shift_dst: assert property (@(posedge clk) disable iff (!rst_n)
    shift_wr |-> (CW'(wdst_r) > lo_r && CW'(wdst_r) <= count_r))
    else $error("entry move outside the insert window");

endmodule
